[rtl/depth_to_color_registration_assert.svh]
// ============================================================================
// depth_to_color_registration_assert.svh
// assertion macros shared by the registration checker
// ============================================================================
`ifndef DEPTH_TO_COLOR_REGISTRATION_ASSERT_SVH
`define DEPTH_TO_COLOR_REGISTRATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DTCR_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtcr check failed");

// next-cycle implication, disabled during reset
`define DTCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtcr check failed");

`endif

[rtl/dtcr_pkg.sv]
// ============================================================================
// dtcr_pkg
// shared constants, register codes and types of the depth to color block
// ============================================================================
package dtcr_pkg;

    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;

    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int DEPTH_W    = 16;
    localparam int LEN_W      = 10;
    localparam int GAIN_W     = 32;
    localparam int TERM_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FRAC_W     = 16;

    localparam int PROD_W     = GAIN_W + COL_W + 1;
    localparam int Q_W        = TERM_W + 1;
    localparam int SUM_W      = Q_W + 2;
    localparam int COORD_W    = SUM_W - FRAC_W;
    localparam int DIV_CNT_W  = $clog2(TERM_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(65536);
    localparam logic [SUM_W-1:0]  FRAC_MASK = SUM_W'((1 << FRAC_W) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_U_COL   = 3'd0,
        CFG_GAIN_U_ROW   = 3'd1,
        CFG_OFFSET_U     = 3'd2,
        CFG_DEPTH_TERM_U = 3'd3,
        CFG_GAIN_V_COL   = 3'd4,
        CFG_GAIN_V_ROW   = 3'd5,
        CFG_OFFSET_V     = 3'd6,
        CFG_DEPTH_TERM_V = 3'd7
    } t_cfg_idx;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL  = 6'b000010,
        F_DIV  = 6'b000100,
        F_SUM  = 6'b001000,
        F_CLS  = 6'b010000,
        F_PUSH = 6'b100000
    } t_fstate;

    typedef struct packed {
        logic               fs;
        logic               keep;
        logic [COL_W-1:0]   u;
        logic [ROW_W-1:0]   v;
        logic [DEPTH_W-1:0] depth;
    } t_entry;

endpackage

[rtl/depth_to_color_registration.sv]
// path: an accepted pixel passes MUL, the two 48-step serial dividers for
// the depth parallax quotients in DIV, then SUM, CLS, PUSH, the queue and
// the output register; a zero-depth pixel goes from MUL straight to PUSH;
// a new pixel waits until the front is idle, also while PUSH waits on a full queue
// reset: synchronous, active low; clears the last written column, empties
// the queue and output register and loads the identity mapping registers
// ============================================================================
// depth_to_color_registration
// maps depth pixels into the color image and emits run-write words
// ============================================================================
module depth_to_color_registration (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dtcr_pkg::DEPTH_W-1:0]    i_depth_sample,
    input  logic [dtcr_pkg::COL_W-1:0]      i_src_col,
    input  logic [dtcr_pkg::ROW_W-1:0]      i_src_row,
    input  logic                            i_frame_start,
    input  logic                            i_cfg_we,
    input  logic [dtcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dtcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [dtcr_pkg::ROW_W-1:0]      o_run_row,
    output logic [dtcr_pkg::COL_W-1:0]      o_run_first_col,
    output logic [dtcr_pkg::LEN_W-1:0]      o_run_length,
    output logic [dtcr_pkg::DEPTH_W-1:0]    o_run_value
);

    logic             push;
    logic             q_full;
    logic             q_vld;
    logic             pop;
    dtcr_pkg::t_entry push_ent;
    dtcr_pkg::t_entry pop_ent;

    dtcr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_depth_sample (i_depth_sample),
        .i_src_col      (i_src_col),
        .i_src_row      (i_src_row),
        .i_frame_start  (i_frame_start),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_push_ent     (push_ent),
        .i_q_full       (q_full)
    );

    dtcr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_vld      (q_vld),
        .o_pop_ent  (pop_ent)
    );

    dtcr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_ent         (pop_ent),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_run_row       (o_run_row),
        .o_run_first_col (o_run_first_col),
        .o_run_length    (o_run_length),
        .o_run_value     (o_run_value)
    );

endmodule

[rtl/dtcr_div.sv]
// ============================================================================
// dtcr_div
// radix-2 restoring divider, one quotient bit per cycle
// ============================================================================
module dtcr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dtcr_pkg::TERM_W-1:0]  i_dividend,
    input  logic [dtcr_pkg::DEPTH_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic [dtcr_pkg::TERM_W-1:0]  o_quotient
);

    logic                            r_busy;
    logic [dtcr_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [dtcr_pkg::DEPTH_W-1:0]    r_den;
    logic [dtcr_pkg::DEPTH_W-1:0]    r_rem;
    logic [dtcr_pkg::TERM_W-1:0]     r_quo;

    logic [dtcr_pkg::DEPTH_W:0]      shifted;
    logic [dtcr_pkg::DEPTH_W:0]      diff;
    logic                            ge;

    assign shifted = {r_rem, r_quo[dtcr_pkg::TERM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= dtcr_pkg::DIV_CNT_W'(dtcr_pkg::TERM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[dtcr_pkg::DEPTH_W-1:0] : shifted[dtcr_pkg::DEPTH_W-1:0];
            r_quo <= {r_quo[dtcr_pkg::TERM_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[rtl/dtcr_front.sv]
// ============================================================================
// dtcr_front
// accepts depth pixels, maps them into the color image and classifies them
// ============================================================================
module dtcr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dtcr_pkg::DEPTH_W-1:0]    i_depth_sample,
    input  logic [dtcr_pkg::COL_W-1:0]      i_src_col,
    input  logic [dtcr_pkg::ROW_W-1:0]      i_src_row,
    input  logic                            i_frame_start,
    input  logic                            i_cfg_we,
    input  logic [dtcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dtcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_push,
    output dtcr_pkg::t_entry                o_push_ent,
    input  logic                            i_q_full
);

    dtcr_pkg::t_fstate r_state, n_state;

    logic [dtcr_pkg::GAIN_W-1:0] r_gu_col, r_gu_row, r_off_u;
    logic [dtcr_pkg::GAIN_W-1:0] r_gv_col, r_gv_row, r_off_v;
    logic [dtcr_pkg::TERM_W-1:0] r_dt_u, r_dt_v;

    logic [dtcr_pkg::DEPTH_W-1:0] r_depth;
    logic [dtcr_pkg::COL_W-1:0]   r_col;
    logic [dtcr_pkg::ROW_W-1:0]   r_row;
    logic                         r_fs;
    logic                         r_keep;
    logic [dtcr_pkg::COL_W-1:0]   r_u;
    logic [dtcr_pkg::ROW_W-1:0]   r_v;

    logic [dtcr_pkg::PROD_W-1:0]  r_pcu, r_pru, r_pcv, r_prv;
    logic [dtcr_pkg::SUM_W-1:0]   r_part_u, r_part_v;
    logic [dtcr_pkg::SUM_W-1:0]   r_sum_u, r_sum_v;

    logic signed [dtcr_pkg::PROD_W-1:0] n_pcu, n_pru, n_pcv, n_prv;
    logic signed [dtcr_pkg::COL_W:0]    col_s, row_s;

    logic                         in_acc;
    logic                         div_start;
    logic                         busy_u, busy_v;
    logic [dtcr_pkg::TERM_W-1:0]  mag_u, mag_v, quo_u, quo_v;
    logic [dtcr_pkg::Q_W-1:0]     qx_u, qx_v, qs_u, qs_v;
    logic [dtcr_pkg::SUM_W-1:0]   adj_u, adj_v;
    logic [dtcr_pkg::COORD_W-1:0] coord_u, coord_v;
    logic                         keep_u, keep_v;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != dtcr_pkg::F_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gu_col <= dtcr_pkg::GAIN_ONE;
            r_gu_row <= '0;
            r_off_u  <= '0;
            r_dt_u   <= '0;
            r_gv_col <= '0;
            r_gv_row <= dtcr_pkg::GAIN_ONE;
            r_off_v  <= '0;
            r_dt_v   <= '0;
        end else if (i_cfg_we) begin
            case (dtcr_pkg::t_cfg_idx'(i_cfg_idx))
                dtcr_pkg::CFG_GAIN_U_COL:   r_gu_col <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_GAIN_U_ROW:   r_gu_row <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_OFFSET_U:     r_off_u  <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_DEPTH_TERM_U: r_dt_u   <= i_cfg_data[dtcr_pkg::TERM_W-1:0];
                dtcr_pkg::CFG_GAIN_V_COL:   r_gv_col <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_GAIN_V_ROW:   r_gv_row <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_OFFSET_V:     r_off_v  <= i_cfg_data[dtcr_pkg::GAIN_W-1:0];
                dtcr_pkg::CFG_DEPTH_TERM_V: r_dt_v   <= i_cfg_data[dtcr_pkg::TERM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        o_push    = 1'b0;
        case (r_state)
            dtcr_pkg::F_IDLE: begin
                if (in_acc) n_state = dtcr_pkg::F_MUL;
            end
            dtcr_pkg::F_MUL: begin
                if (r_depth == '0) begin
                    n_state = dtcr_pkg::F_PUSH;
                end else begin
                    div_start = 1'b1;
                    n_state   = dtcr_pkg::F_DIV;
                end
            end
            dtcr_pkg::F_DIV: begin
                if (!busy_u) n_state = dtcr_pkg::F_SUM;
            end
            dtcr_pkg::F_SUM: n_state = dtcr_pkg::F_CLS;
            dtcr_pkg::F_CLS: n_state = dtcr_pkg::F_PUSH;
            dtcr_pkg::F_PUSH: begin
                if (!(r_keep || r_fs)) begin
                    n_state = dtcr_pkg::F_IDLE;
                end else if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = dtcr_pkg::F_IDLE;
                end
            end
            default: n_state = dtcr_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtcr_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // depth term magnitudes into the dividers
    assign mag_u = r_dt_u[dtcr_pkg::TERM_W-1] ? (-r_dt_u) : r_dt_u;
    assign mag_v = r_dt_v[dtcr_pkg::TERM_W-1] ? (-r_dt_v) : r_dt_v;

    dtcr_div u_div_u (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_u),
        .i_divisor  (r_depth),
        .o_busy     (busy_u),
        .o_quotient (quo_u)
    );

    dtcr_div u_div_v (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_v),
        .i_divisor  (r_depth),
        .o_busy     (busy_v),
        .o_quotient (quo_v)
    );

    // signed quotient, truncated toward zero
    assign qx_u = {1'b0, quo_u};
    assign qx_v = {1'b0, quo_v};
    assign qs_u = r_dt_u[dtcr_pkg::TERM_W-1] ? (-qx_u) : qx_u;
    assign qs_v = r_dt_v[dtcr_pkg::TERM_W-1] ? (-qx_v) : qx_v;

    assign col_s = $signed({1'b0, r_col});
    assign row_s = $signed({2'b00, r_row});
    assign n_pcu = $signed(r_gu_col) * col_s;
    assign n_pru = $signed(r_gu_row) * row_s;
    assign n_pcv = $signed(r_gv_col) * col_s;
    assign n_prv = $signed(r_gv_row) * row_s;

    // integer coordinate, rounded toward zero
    assign adj_u   = r_sum_u + (r_sum_u[dtcr_pkg::SUM_W-1] ? dtcr_pkg::FRAC_MASK : '0);
    assign adj_v   = r_sum_v + (r_sum_v[dtcr_pkg::SUM_W-1] ? dtcr_pkg::FRAC_MASK : '0);
    assign coord_u = adj_u[dtcr_pkg::SUM_W-1:dtcr_pkg::FRAC_W];
    assign coord_v = adj_v[dtcr_pkg::SUM_W-1:dtcr_pkg::FRAC_W];
    assign keep_u  = !coord_u[dtcr_pkg::COORD_W-1]
                     && (coord_u < dtcr_pkg::COORD_W'(dtcr_pkg::IMG_WIDTH));
    assign keep_v  = !coord_v[dtcr_pkg::COORD_W-1]
                     && (coord_v < dtcr_pkg::COORD_W'(dtcr_pkg::IMG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_depth <= i_depth_sample;
            r_col   <= i_src_col;
            r_row   <= i_src_row;
            r_fs    <= i_frame_start;
        end
        if (r_state == dtcr_pkg::F_MUL) begin
            r_pcu  <= n_pcu;
            r_pru  <= n_pru;
            r_pcv  <= n_pcv;
            r_prv  <= n_prv;
            r_keep <= 1'b0;
        end
        if (r_state == dtcr_pkg::F_DIV) begin
            r_part_u <= {{(dtcr_pkg::SUM_W-dtcr_pkg::PROD_W){r_pcu[dtcr_pkg::PROD_W-1]}}, r_pcu}
                      + {{(dtcr_pkg::SUM_W-dtcr_pkg::PROD_W){r_pru[dtcr_pkg::PROD_W-1]}}, r_pru}
                      + {{(dtcr_pkg::SUM_W-dtcr_pkg::GAIN_W){r_off_u[dtcr_pkg::GAIN_W-1]}}, r_off_u};
            r_part_v <= {{(dtcr_pkg::SUM_W-dtcr_pkg::PROD_W){r_pcv[dtcr_pkg::PROD_W-1]}}, r_pcv}
                      + {{(dtcr_pkg::SUM_W-dtcr_pkg::PROD_W){r_prv[dtcr_pkg::PROD_W-1]}}, r_prv}
                      + {{(dtcr_pkg::SUM_W-dtcr_pkg::GAIN_W){r_off_v[dtcr_pkg::GAIN_W-1]}}, r_off_v};
        end
        if (r_state == dtcr_pkg::F_SUM) begin
            r_sum_u <= r_part_u + {{(dtcr_pkg::SUM_W-dtcr_pkg::Q_W){qs_u[dtcr_pkg::Q_W-1]}}, qs_u};
            r_sum_v <= r_part_v + {{(dtcr_pkg::SUM_W-dtcr_pkg::Q_W){qs_v[dtcr_pkg::Q_W-1]}}, qs_v};
        end
        if (r_state == dtcr_pkg::F_CLS) begin
            r_u    <= coord_u[dtcr_pkg::COL_W-1:0];
            r_v    <= coord_v[dtcr_pkg::ROW_W-1:0];
            r_keep <= keep_u && keep_v && !busy_v;
        end
    end

    always_comb begin
        o_push_ent.fs    = r_fs;
        o_push_ent.keep  = r_keep;
        o_push_ent.u     = r_u;
        o_push_ent.v     = r_v;
        o_push_ent.depth = r_depth;
    end

endmodule

[rtl/dtcr_queue.sv]
// ============================================================================
// dtcr_queue
// short word queue between the mapping front and the run back end
// ============================================================================
module dtcr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dtcr_pkg::t_entry i_push_ent,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_vld,
    output dtcr_pkg::t_entry o_pop_ent
);

    dtcr_pkg::t_entry              r_mem [dtcr_pkg::QUEUE_DEPTH];
    logic [dtcr_pkg::QPTR_W-1:0]   r_wp;
    logic [dtcr_pkg::QPTR_W-1:0]   r_rp;
    logic [dtcr_pkg::QCNT_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == dtcr_pkg::QCNT_W'(dtcr_pkg::QUEUE_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_push_ent;
    end

    assign o_pop_ent = r_mem[r_rp];

endmodule

[rtl/dtcr_back.sv]
// ============================================================================
// dtcr_back
// tracks the last written column and builds run-write descriptors
// ============================================================================
module dtcr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_vld,
    input  dtcr_pkg::t_entry              i_q_ent,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dtcr_pkg::ROW_W-1:0]    o_run_row,
    output logic [dtcr_pkg::COL_W-1:0]    o_run_first_col,
    output logic [dtcr_pkg::LEN_W-1:0]    o_run_length,
    output logic [dtcr_pkg::DEPTH_W-1:0]  o_run_value
);

    logic                          r_out_vld;
    logic [dtcr_pkg::COL_W-1:0]    r_lwc;
    logic [dtcr_pkg::ROW_W-1:0]    r_row;
    logic [dtcr_pkg::COL_W-1:0]    r_first;
    logic [dtcr_pkg::LEN_W-1:0]    r_len;
    logic [dtcr_pkg::DEPTH_W-1:0]  r_val;

    logic [dtcr_pkg::COL_W-1:0]    base;
    logic [dtcr_pkg::COL_W:0]      base_p1;
    logic                          ahead;
    logic [dtcr_pkg::COL_W-1:0]    n_first;
    logic [dtcr_pkg::LEN_W-1:0]    n_len;
    logic                          taken;

    assign taken   = r_out_vld && !i_out_stall;
    assign o_pop   = i_q_vld && (!r_out_vld || !i_out_stall);

    assign base    = i_q_ent.fs ? '0 : r_lwc;
    assign base_p1 = {1'b0, base} + 1'b1;
    assign ahead   = {1'b0, i_q_ent.u} > base_p1;
    assign n_first = ahead ? base_p1[dtcr_pkg::COL_W-1:0] : i_q_ent.u;
    assign n_len   = ahead ? dtcr_pkg::LEN_W'(i_q_ent.u - base) : dtcr_pkg::LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_lwc     <= '0;
        end else begin
            if (o_pop && i_q_ent.keep) begin
                r_out_vld <= 1'b1;
            end else if (taken) begin
                r_out_vld <= 1'b0;
            end
            if (o_pop) begin
                if (i_q_ent.keep) begin
                    r_lwc <= i_q_ent.u;
                end else if (i_q_ent.fs) begin
                    r_lwc <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_ent.keep) begin
            r_row   <= i_q_ent.v;
            r_first <= n_first;
            r_len   <= n_len;
            r_val   <= i_q_ent.depth;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_run_row       = r_row;
    assign o_run_first_col = r_first;
    assign o_run_length    = r_len;
    assign o_run_value     = r_val;

endmodule

[rtl/dtcr_checker.sv]
// ============================================================================
// dtcr_checker
// port-level checks of the depth to color registration block
// ============================================================================
`include "depth_to_color_registration_assert.svh"

module dtcr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [dtcr_pkg::ROW_W-1:0]      o_run_row,
    input logic [dtcr_pkg::COL_W-1:0]      o_run_first_col,
    input logic [dtcr_pkg::LEN_W-1:0]      o_run_length,
    input logic [dtcr_pkg::DEPTH_W-1:0]    o_run_value
);

    logic [dtcr_pkg::COL_W:0] run_end;

    assign run_end = {1'b0, o_run_first_col} + {1'b0, o_run_length};

    // one pixel in flight at a time
    `DTCR_ASSERT_NEXT(a_in_busy, (i_in_valid && !o_in_stall), o_in_stall)

    // a stalled run word holds
    `DTCR_ASSERT_NEXT(a_out_hold, (o_out_valid && i_out_stall),
        (o_out_valid && $stable(o_run_row) && $stable(o_run_first_col)
         && $stable(o_run_length) && $stable(o_run_value)))

    // a run is never empty and stays inside the row
    `DTCR_ASSERT_HOLDS(a_run_fits, o_out_valid,
        ((o_run_length != '0) && (run_end <= (dtcr_pkg::COL_W + 1)'(dtcr_pkg::IMG_WIDTH))))

    // target row in range and never a zero depth
    `DTCR_ASSERT_HOLDS(a_run_row, o_out_valid,
        ((o_run_row < dtcr_pkg::ROW_W'(dtcr_pkg::IMG_HEIGHT)) && (o_run_value != '0)))

endmodule

bind depth_to_color_registration dtcr_checker u_dtcr_checker (.*);
